// ----- design/eam_pkg.sv -----
package eam_pkg;

	localparam int TIME_W   = 32;
	localparam int TEMP_W   = 9;
	localparam int PERIOD_W = 16;
	localparam int CEIL_W   = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [TIME_W-1:0]        time_t;

	localparam logic [1:0] REG_LOW_LIMIT      = 2'd0;
	localparam logic [1:0] REG_HIGH_LIMIT     = 2'd1;
	localparam logic [1:0] REG_REPORT_PERIOD  = 2'd2;
	localparam logic [1:0] REG_GLITCH_CEILING = 2'd3;

	localparam logic [1:0] TEMP_NORMAL = 2'd0;
	localparam logic [1:0] TEMP_LOW    = 2'd1;
	localparam logic [1:0] TEMP_HIGH   = 2'd2;

	localparam logic [1:0] DOOR_NONE   = 2'd0;
	localparam logic [1:0] DOOR_OPENED = 2'd1;
	localparam logic [1:0] DOOR_CLOSED = 2'd2;

	localparam temp_t                LOW_LIMIT_RESET      = 9'sd19;
	localparam temp_t                HIGH_LIMIT_RESET     = 9'sd30;
	localparam logic [PERIOD_W-1:0]  REPORT_PERIOD_RESET  = 16'd60;
	localparam logic [CEIL_W-1:0]    GLITCH_CEILING_RESET = 8'd150;
	localparam temp_t                GOOD_TEMP_RESET      = 9'sd20;

endpackage

// ----- design/environment_alarm_monitor_core.sv -----
// Channel   Handshake                   Payload
// in        in_valid / in_ready         raw_temperature, door_open, now_seconds
// out       out_valid / out_ready       failure, temp_state, temperature_used,
//                                       report_temp, door_event
// cfg       APB psel/penable/pwrite     paddr[3:0], pwdata, prdata, pready
//
// One request per clock sustained while out is not stalled, through one input
// register and one result register; out_valid rises as the result is loaded.
// The alarm and report-time state updates as the request moves into the result
// register, so the next request always sees the previous one's state.
// A stall on out holds the result register and the input register; in_ready
// drops only when both are full and out_ready is low.
// arst_n clears control state, alarm flags, report time and loads the register
// reset values; last good reading resets to 20.
module environment_alarm_monitor_core
	import eam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  temp_t               raw_temperature,
	input  logic                door_open,
	input  logic [31:0]         now_seconds,

	output logic                out_valid,
	input  logic                out_ready,
	output logic                failure,
	output logic [1:0]          temp_state,
	output temp_t               temperature_used,
	output logic                report_temp,
	output logic [1:0]          door_event,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	temp_t                low_limit_q;
	temp_t                high_limit_q;
	logic [PERIOD_W-1:0]  report_period_q;
	logic [CEIL_W-1:0]    glitch_ceiling_q;

	logic                 low_alarm_q;
	logic                 high_alarm_q;
	logic                 door_alarm_q;
	time_t                last_report_q;
	temp_t                last_good_q;

	logic                 valid_s1;
	temp_t                raw_s1;
	logic                 door_s1;
	time_t                now_s1;

	logic                 out_valid_q;
	logic                 failure_q;
	logic [1:0]           temp_state_q;
	temp_t                temp_used_q;
	logic                 report_q;
	logic [1:0]           door_event_q;

	logic                 advance;
	logic                 cfg_write;
	logic                 good;
	temp_t                t_used;
	logic                 low_d;
	logic                 high_d;
	logic                 door_d;
	logic                 report_d;
	logic [1:0]           door_ev_d;
	logic [1:0]           state_d;
	time_t                elapsed;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q      <= LOW_LIMIT_RESET;
			high_limit_q     <= HIGH_LIMIT_RESET;
			report_period_q  <= REPORT_PERIOD_RESET;
			glitch_ceiling_q <= GLITCH_CEILING_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_LOW_LIMIT:      low_limit_q      <= temp_t'(pwdata[TEMP_W-1:0]);
				REG_HIGH_LIMIT:     high_limit_q     <= temp_t'(pwdata[TEMP_W-1:0]);
				REG_REPORT_PERIOD:  report_period_q  <= pwdata[PERIOD_W-1:0];
				REG_GLITCH_CEILING: glitch_ceiling_q <= pwdata[CEIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LOW_LIMIT:
				prdata = {{(DATA_W-TEMP_W){low_limit_q[TEMP_W-1]}}, low_limit_q};
			REG_HIGH_LIMIT:
				prdata = {{(DATA_W-TEMP_W){high_limit_q[TEMP_W-1]}}, high_limit_q};
			REG_REPORT_PERIOD:
				prdata = {{(DATA_W-PERIOD_W){1'b0}}, report_period_q};
			REG_GLITCH_CEILING:
				prdata = {{(DATA_W-CEIL_W){1'b0}}, glitch_ceiling_q};
			default:
				prdata = '0;
		endcase
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1  <= raw_temperature;
			door_s1 <= door_open;
			now_s1  <= TIME_W'(now_seconds);
		end
	end

	always_comb begin
		good      = (raw_s1 != '0) &&
		            (raw_s1[TEMP_W-1] || (raw_s1[CEIL_W-1:0] < glitch_ceiling_q));
		t_used    = good ? raw_s1 : last_good_q;
		low_d     = low_alarm_q;
		high_d    = high_alarm_q;
		report_d  = 1'b0;
		if (t_used < low_limit_q) begin
			report_d = !low_alarm_q;
			low_d    = 1'b1;
			high_d   = 1'b0;
		end else if (t_used > high_limit_q) begin
			report_d = !high_alarm_q;
			high_d   = 1'b1;
			low_d    = 1'b0;
		end else if ((t_used > low_limit_q) && (t_used < high_limit_q)) begin
			report_d = low_alarm_q || high_alarm_q;
			low_d    = 1'b0;
			high_d   = 1'b0;
		end
		elapsed = now_s1 - last_report_q;
		if (elapsed >= TIME_W'(report_period_q)) begin
			report_d = 1'b1;
		end
		door_d    = door_s1;
		door_ev_d = DOOR_NONE;
		if (door_s1 && !door_alarm_q) begin
			door_ev_d = DOOR_OPENED;
		end else if (!door_s1 && door_alarm_q) begin
			door_ev_d = DOOR_CLOSED;
		end
		state_d = low_d ? TEMP_LOW : (high_d ? TEMP_HIGH : TEMP_NORMAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_alarm_q   <= 1'b0;
			high_alarm_q  <= 1'b0;
			door_alarm_q  <= 1'b0;
			last_report_q <= '0;
			last_good_q   <= GOOD_TEMP_RESET;
		end else if (advance) begin
			low_alarm_q  <= low_d;
			high_alarm_q <= high_d;
			door_alarm_q <= door_d;
			last_good_q  <= t_used;
			if (report_d) begin
				last_report_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			failure_q    <= door_d || low_d || high_d;
			temp_state_q <= state_d;
			temp_used_q  <= t_used;
			report_q     <= report_d;
			door_event_q <= door_ev_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign failure          = failure_q;
	assign temp_state       = temp_state_q;
	assign temperature_used = temp_used_q;
	assign report_temp      = report_q;
	assign door_event       = door_event_q;

	a_alarm_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(low_alarm_q && high_alarm_q))
		else $error("low and high alarm both set");

	a_report_time: assert property (@(posedge clk) disable iff (!arst_n)
		advance && report_d |=> last_report_q == $past(now_s1))
		else $error("report time not taken");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1))
		else $error("stalled request dropped");

	a_door_open_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (door_ev_d == DOOR_OPENED) |=> door_alarm_q)
		else $error("door open event without door flag");

endmodule

// ----- sim/alarm_pass_checker.sv -----
module alarm_pass_checker
	import eam_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  temp_t             raw_temperature,
	input  logic              door_open,
	input  logic [31:0]       now_seconds,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              failure,
	input  logic [1:0]        temp_state,
	input  temp_t             temperature_used,
	input  logic              report_temp,
	input  logic [1:0]        door_event,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                outstanding,
	output int                fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       failure;
		logic [1:0] temp_state;
		temp_t      temperature_used;
		logic       report_temp;
		logic [1:0] door_event;
	} alarm_pass_t;

	temp_t               lim_low;
	temp_t               lim_high;
	logic [PERIOD_W-1:0] period;
	logic [CEIL_W-1:0]   ceiling;
	logic                below_flag;
	logic                above_flag;
	logic                door_flag;
	time_t               reported_at;
	temp_t               good_reading;
	alarm_pass_t         expected_passes[$];
	int                  mismatches;

	function automatic alarm_pass_t monitor_pass(input temp_t raw, input logic door_now,
			input time_t now);
		alarm_pass_t res;
		temp_t       reading;
		time_t       elapsed;
		logic        report;
		res = '0;
		report = 1'b0;
		reading = raw;
		if (raw != 0 && int'(raw) < int'(ceiling))
			good_reading = raw;
		else
			reading = good_reading;
		if (reading < lim_low) begin
			if (!below_flag)
				report = 1'b1;
			below_flag = 1'b1;
			above_flag = 1'b0;
		end else if (reading > lim_high) begin
			if (!above_flag)
				report = 1'b1;
			above_flag = 1'b1;
			below_flag = 1'b0;
		end else if (reading > lim_low && reading < lim_high) begin
			if (below_flag || above_flag)
				report = 1'b1;
			below_flag = 1'b0;
			above_flag = 1'b0;
		end
		elapsed = now - reported_at;
		if (elapsed >= time_t'(period))
			report = 1'b1;
		if (report)
			reported_at = now;
		res.door_event = DOOR_NONE;
		if (door_now) begin
			if (!door_flag) begin
				door_flag = 1'b1;
				res.door_event = DOOR_OPENED;
			end
		end else if (door_flag) begin
			door_flag = 1'b0;
			res.door_event = DOOR_CLOSED;
		end
		res.failure = door_flag | below_flag | above_flag;
		res.temp_state = below_flag ? TEMP_LOW : (above_flag ? TEMP_HIGH : TEMP_NORMAL);
		res.temperature_used = reading;
		res.report_temp = report;
		return res;
	endfunction

	task automatic note_mismatch(input string what, input alarm_pass_t want,
			input alarm_pass_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected failure=%0b state=%0d temp=%0d report=%0b door=%0d",
				$time, what, want.failure, want.temp_state, want.temperature_used,
				want.report_temp, want.door_event,
				"; got failure=%0b state=%0d temp=%0d report=%0b door=%0d",
				got.failure, got.temp_state, got.temperature_used,
				got.report_temp, got.door_event);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		alarm_pass_t got;
		alarm_pass_t want;
		if (!arst_n) begin
			lim_low = LOW_LIMIT_RESET;
			lim_high = HIGH_LIMIT_RESET;
			period = REPORT_PERIOD_RESET;
			ceiling = GLITCH_CEILING_RESET;
			below_flag = 1'b0;
			above_flag = 1'b0;
			door_flag = 1'b0;
			reported_at = '0;
			good_reading = GOOD_TEMP_RESET;
			expected_passes.delete();
			mismatches = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_LOW_LIMIT:      lim_low = pwdata[TEMP_W-1:0];
					REG_HIGH_LIMIT:     lim_high = pwdata[TEMP_W-1:0];
					REG_REPORT_PERIOD:  period = pwdata[PERIOD_W-1:0];
					REG_GLITCH_CEILING: ceiling = pwdata[CEIL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {failure, temp_state, temperature_used, report_temp, door_event};
				if (expected_passes.size() == 0) begin
					note_mismatch("result with no request outstanding", '0, got);
				end else begin
					want = expected_passes.pop_front();
					if (got !== want)
						note_mismatch("result differs", want, got);
				end
			end
			if (in_valid && in_ready)
				expected_passes.insert(expected_passes.size(),
					monitor_pass(raw_temperature, door_open, now_seconds));
			outstanding <= expected_passes.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import eam_pkg::*;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	temp_t             raw_temperature = '0;
	logic              door_open = 1'b0;
	logic [31:0]       now_seconds = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              failure;
	logic [1:0]        temp_state;
	temp_t             temperature_used;
	logic              report_temp;
	logic [1:0]        door_event;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                outstanding;
	int                fail_count;
	int                send_idle = 19;
	int                recv_idle = 88;
	int                cur_low = 19;
	int                cur_high = 30;
	int                cur_period = 60;
	int                cur_ceiling = 150;
	time_t             clock_now = '0;
	logic              door_level = 1'b0;

	environment_alarm_monitor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_temperature(raw_temperature),
		.door_open(door_open),
		.now_seconds(now_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.failure(failure),
		.temp_state(temp_state),
		.temperature_used(temperature_used),
		.report_temp(report_temp),
		.door_event(door_event),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	alarm_pass_checker pass_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_temperature(raw_temperature),
		.door_open(door_open),
		.now_seconds(now_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.failure(failure),
		.temp_state(temp_state),
		.temperature_used(temperature_used),
		.report_temp(report_temp),
		.door_event(door_event),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("environment_alarm_monitor_core test failed");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle);

	task automatic send_pass(input int t, input logic door, input time_t now);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temperature <= temp_t'(t);
		door_open <= door;
		now_seconds <= now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input int lo, input int hi, input int per, input int ceil_val);
		logic [31:0] junk;
		wait_drained();
		junk = $urandom();
		write_reg(REG_LOW_LIMIT, {junk[31:TEMP_W], TEMP_W'(lo)});
		junk = $urandom();
		write_reg(REG_HIGH_LIMIT, {junk[31:TEMP_W], TEMP_W'(hi)});
		junk = $urandom();
		write_reg(REG_REPORT_PERIOD, {junk[31:PERIOD_W], PERIOD_W'(per)});
		junk = $urandom();
		write_reg(REG_GLITCH_CEILING, {junk[31:CEIL_W], CEIL_W'(ceil_val)});
		cur_low = lo;
		cur_high = hi;
		cur_period = per;
		cur_ceiling = ceil_val;
	endtask

	task automatic random_pass();
		int t;
		int sel;
		if ($urandom_range(0, 199) == 0)
			wait_drained();
		sel = $urandom_range(0, 99);
		if (sel < 30)
			t = cur_low + int'($urandom_range(0, 6)) - 3;
		else if (sel < 60)
			t = cur_high + int'($urandom_range(0, 6)) - 3;
		else if (sel < 75)
			t = (cur_high > cur_low) ?
				cur_low + int'($urandom_range(0, cur_high - cur_low)) : cur_low;
		else if (sel < 85)
			t = ($urandom_range(0, 1) == 1) ?
				0 : cur_ceiling + int'($urandom_range(0, 255 - cur_ceiling));
		else
			t = int'($urandom_range(0, 511)) - 256;
		if (t < -256 || t > 255)
			t = int'($urandom_range(0, 511)) - 256;
		sel = $urandom_range(0, 99);
		if (sel < 65)
			clock_now += $urandom_range(0, cur_period / 4 + 3);
		else if (sel < 88)
			clock_now += cur_period + int'($urandom_range(0, 2)) - 1;
		else if (sel < 96)
			clock_now = $urandom();
		else
			clock_now = 32'hFFFF_FFFF - $urandom_range(0, 8);
		if ($urandom_range(0, 99) < 15)
			door_level = ~door_level;
		send_pass(t, door_level, clock_now);
	endtask

	initial begin : stimulus
		int lo;
		int hi;
		int per;
		int ceil_val;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_pass(25, 1'b0, 32'd10);
		send_pass(0, 1'b0, 32'd20);
		send_pass(150, 1'b0, 32'd30);
		send_pass(149, 1'b0, 32'd40);
		send_pass(255, 1'b1, 32'd50);
		send_pass(30, 1'b1, 32'd60);
		send_pass(-256, 1'b0, 32'd70);
		send_pass(19, 1'b0, 32'd80);
		send_pass(-1, 1'b0, 32'd90);
		send_pass(20, 1'b0, 32'd100);
		send_pass(31, 1'b0, 32'd160);
		send_pass(25, 1'b0, 32'd220);
		send_pass(25, 1'b0, 32'd280);
		send_pass(25, 1'b0, 32'd339);
		send_pass(25, 1'b1, 32'hFFFF_FFF0);
		send_pass(25, 1'b1, 32'h0000_0010);
		send_pass(1, 1'b0, 32'h0000_0050);

		set_limits(-256, 255, 0, 0);
		send_pass(5, 1'b0, 32'd500);
		send_pass(255, 1'b0, 32'd501);
		send_pass(-256, 1'b1, 32'd502);
		send_pass(-255, 1'b0, 32'd503);

		set_limits(255, -256, 65535, 255);
		send_pass(100, 1'b0, 32'd600);
		send_pass(254, 1'b0, 32'd601);
		send_pass(255, 1'b1, 32'd602);
		send_pass(-256, 1'b0, 32'd603);

		for (int ph = 0; ph < 12; ph++) begin
			send_idle = (ph < 4) ? 19 : ((ph < 8) ? 88 : 0);
			recv_idle = (ph < 4) ? 88 : ((ph < 8) ? 19 : 0);
			lo = int'($urandom_range(0, 120)) - 60;
			hi = lo + int'($urandom_range(0, 40));
			per = $urandom_range(1, 120);
			ceil_val = $urandom_range(80, 255);
			case (ph)
				1: per = 0;
				2: begin
					lo = -256;
					hi = 255;
				end
				3: ceil_val = 255;
				5: per = 65535;
				7: begin
					lo = hi;
					hi = hi - 15;
				end
				9: ceil_val = 1;
				10: ceil_val = 0;
				11: begin
					lo = int'($urandom_range(0, 511)) - 256;
					hi = int'($urandom_range(0, 511)) - 256;
					per = $urandom_range(0, 65535);
					ceil_val = $urandom_range(0, 255);
				end
				default: ;
			endcase
			set_limits(lo, hi, per, ceil_val);
			repeat (75) random_pass();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("environment_alarm_monitor_core test passed");
		else
			$display("environment_alarm_monitor_core test failed");
		$finish;
	end

endmodule
